@@ rtl/sab_pkg.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton builder package
// Field widths, default sizes, datapath command codes and status bundle.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int SYMBOL_W     = 5;
    localparam int STATE_W      = 11;
    localparam int NEWSUB_W     = 11;
    localparam int TOTAL_W      = 20;
    localparam int DEF_MAX_LEN  = 1024;
    localparam int DEF_ALPHABET = 26;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_CLR,
        OP_ALLOC,
        OP_LEN_CUR,
        OP_CLR_CUR,
        OP_W1_RD,
        OP_W1_EX,
        OP_RD_LQ,
        OP_CMP,
        OP_CL_LINK,
        OP_CL_LQ,
        OP_CL_LC,
        OP_COPY,
        OP_COPY_TAIL,
        OP_W2_RD,
        OP_W2_EX,
        OP_FIN,
        OP_SKIP
    } op_t;

    typedef struct packed {
        logic start;
        logic sym_ok;
        logic full;
        logic j_last;
        logic tr_zero;
        logic tr_is_q;
        logic link_zero;
        logic len_match;
        logic out_busy;
    } stat_t;

endpackage

@@ rtl/sab_req_if.sv @@
// ----------------------------------------------------------------------------
// Symbol request channel
// Carries one appended symbol and the start flag per item.
// ----------------------------------------------------------------------------
interface sab_req_if;
    import sab_pkg::*;

    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                start_new;

    modport source (output valid, output symbol, output start_new, input ready);
    modport sink (input valid, input symbol, input start_new, output ready);
endinterface

@@ rtl/sab_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Carries the new state, added substrings, running total and full flag.
// ----------------------------------------------------------------------------
interface sab_rsp_if;
    import sab_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATE_W-1:0]  state_index;
    logic [NEWSUB_W-1:0] new_substrings;
    logic [TOTAL_W-1:0]  total_substrings;
    logic                full_res;

    modport source (output valid, output state_index, output new_substrings,
                    output total_substrings, output full_res, input ready);
    modport sink (input valid, input state_index, input new_substrings,
                  input total_substrings, input full_res, output ready);
endinterface

@@ rtl/suffix_automaton_builder_core.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton builder core
// Appends one symbol per item to an online suffix automaton and reports the
// new state, the distinct substrings it adds and the running total.
// ----------------------------------------------------------------------------
// Sequence: latch the item, allocate the new state, set its length and clear its
// transition row, then walk suffix links; on an existing transition compare
// lengths and, when a clone occurs, copy the row and walk the redirects. Ignored symbols skip to the result.
// Throughput: one item at a time; the next item is accepted the cycle after the
// result is loaded. A start flag first clears the root row.
// Reset clears the root row before the first item is accepted.
module suffix_automaton_builder_core #(
    parameter int MAX_LEN  = sab_pkg::DEF_MAX_LEN,
    parameter int ALPHABET = sab_pkg::DEF_ALPHABET
) (
    input logic       clk,
    input logic       rst_n,
    sab_req_if.sink   req,
    sab_rsp_if.source rsp
);
    import sab_pkg::*;

    op_t   op;
    stat_t stat;

    sab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .op       (op)
    );

    sab_datapath #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .symbol           (req.symbol),
        .start_new        (req.start_new),
        .out_ready        (rsp.ready),
        .stat             (stat),
        .out_valid        (rsp.valid),
        .state_index      (rsp.state_index),
        .new_substrings   (rsp.new_substrings),
        .total_substrings (rsp.total_substrings),
        .full_res         (rsp.full_res)
    );
endmodule

@@ rtl/sab_datapath.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton datapath
// Holds the length, link and transition memories and the working registers,
// and carries out one command from the controller per cycle.
// ----------------------------------------------------------------------------
module sab_datapath #(
    parameter int MAX_LEN  = sab_pkg::DEF_MAX_LEN,
    parameter int ALPHABET = sab_pkg::DEF_ALPHABET
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sab_pkg::op_t                  op,
    input  logic [sab_pkg::SYMBOL_W-1:0]  symbol,
    input  logic                          start_new,
    input  logic                          out_ready,
    output sab_pkg::stat_t                stat,
    output logic                          out_valid,
    output logic [sab_pkg::STATE_W-1:0]   state_index,
    output logic [sab_pkg::NEWSUB_W-1:0]  new_substrings,
    output logic [sab_pkg::TOTAL_W-1:0]   total_substrings,
    output logic                          full_res
);
    import sab_pkg::*;

    localparam int NST   = 2 * MAX_LEN;
    localparam int SW    = $clog2(NST);
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int CW    = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
    localparam int AW    = SW + CW;
    localparam int TDEP  = 2 ** AW;
    localparam logic [SW-1:0] ROOT  = SW'(1);
    localparam logic [CW-1:0] J_MAX = CW'(ALPHABET - 1);

    logic [LW-1:0] len_mem  [NST];
    logic [SW-1:0] link_mem [NST];
    logic [SW-1:0] tr_mem   [TDEP];

    logic          len_we, len_re, link_we, link_re, tr_we, tr_re;
    logic [SW-1:0] len_waddr, len_raddr, link_waddr, link_raddr;
    logic [LW-1:0] len_wdata;
    logic [SW-1:0] link_wdata, tr_wdata;
    logic [AW-1:0] tr_waddr, tr_raddr;
    logic [LW-1:0] len_rd;
    logic [SW-1:0] link_rd, tr_rd;

    logic [CW-1:0] c_reg, j_reg, jd_reg;
    logic          ok_reg, start_reg, cpv_reg;
    logic [SW-1:0] count_reg, last_reg, cur_reg, p_reg, q_reg, cl_reg;
    logic [LW-1:0] slen_reg, lencur_reg, lenlink_reg, lenp_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic          out_valid_reg;
    logic [STATE_W-1:0]  idx_reg;
    logic [NEWSUB_W-1:0] new_reg;
    logic [TOTAL_W-1:0]  tot_reg;
    logic          full_reg;

    logic [SW:0]   cnt_inc;
    logic [SW-1:0] cnt_new;
    logic [LW-1:0] added;
    logic [LW-1:0] lenp_inc;
    logic [CW-1:0] j_next;

    assign cnt_inc  = {1'b0, count_reg} + (SW+1)'(1);
    assign cnt_new  = (cnt_inc >= (SW+1)'(NST)) ? SW'(NST - 1) : cnt_inc[SW-1:0];
    assign added    = lencur_reg - lenlink_reg;
    assign lenp_inc = lenp_reg + LW'(1);
    assign j_next   = (j_reg == J_MAX) ? '0 : j_reg + CW'(1);

    assign stat.start     = start_reg;
    assign stat.sym_ok    = ok_reg;
    assign stat.full      = (slen_reg >= LW'(MAX_LEN));
    assign stat.j_last    = (j_reg == J_MAX);
    assign stat.tr_zero   = (tr_rd == '0);
    assign stat.tr_is_q   = (tr_rd == q_reg);
    assign stat.link_zero = (link_rd == '0);
    assign stat.len_match = ((lenp_reg + LW'(1)) == len_rd);
    assign stat.out_busy  = out_valid_reg && !out_ready;

    always_comb
    begin
        len_we     = 1'b0;
        len_re     = 1'b0;
        link_we    = 1'b0;
        link_re    = 1'b0;
        tr_we      = 1'b0;
        tr_re      = 1'b0;
        len_waddr  = cur_reg;
        len_raddr  = p_reg;
        len_wdata  = '0;
        link_waddr = cur_reg;
        link_raddr = p_reg;
        link_wdata = '0;
        tr_waddr   = {p_reg, c_reg};
        tr_raddr   = {p_reg, c_reg};
        tr_wdata   = '0;
        unique case (op)
            OP_CLR:
            begin
                tr_we      = 1'b1;
                tr_waddr   = {ROOT, j_reg};
                len_we     = 1'b1;
                len_waddr  = ROOT;
                link_we    = 1'b1;
                link_waddr = ROOT;
            end
            OP_ALLOC:
            begin
                len_re    = 1'b1;
                len_raddr = last_reg;
            end
            OP_LEN_CUR:
            begin
                len_we    = 1'b1;
                len_wdata = len_rd + LW'(1);
            end
            OP_CLR_CUR:
            begin
                tr_we    = 1'b1;
                tr_waddr = {cur_reg, j_reg};
            end
            OP_W1_RD, OP_W2_RD:
            begin
                tr_re   = 1'b1;
                link_re = 1'b1;
            end
            OP_W1_EX:
            begin
                if (tr_rd == '0)
                begin
                    tr_we    = 1'b1;
                    tr_wdata = cur_reg;
                    if (link_rd == '0)
                    begin
                        link_we    = 1'b1;
                        link_wdata = ROOT;
                    end
                end
                else
                begin
                    len_re = 1'b1;
                end
            end
            OP_RD_LQ:
            begin
                len_re    = 1'b1;
                len_raddr = q_reg;
            end
            OP_CMP:
            begin
                if (stat.len_match)
                begin
                    link_we    = 1'b1;
                    link_wdata = q_reg;
                end
                else
                begin
                    len_we     = 1'b1;
                    len_waddr  = cnt_new;
                    len_wdata  = lenp_inc;
                    link_re    = 1'b1;
                    link_raddr = q_reg;
                end
            end
            OP_CL_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = cl_reg;
                link_wdata = link_rd;
            end
            OP_CL_LQ:
            begin
                link_we    = 1'b1;
                link_waddr = q_reg;
                link_wdata = cl_reg;
            end
            OP_CL_LC:
            begin
                link_we    = 1'b1;
                link_wdata = cl_reg;
            end
            OP_COPY:
            begin
                tr_re    = 1'b1;
                tr_raddr = {q_reg, j_reg};
                tr_we    = cpv_reg;
                tr_waddr = {cl_reg, jd_reg};
                tr_wdata = tr_rd;
            end
            OP_COPY_TAIL:
            begin
                tr_we    = 1'b1;
                tr_waddr = {cl_reg, jd_reg};
                tr_wdata = tr_rd;
            end
            OP_W2_EX:
            begin
                if (tr_rd == q_reg)
                begin
                    tr_we    = 1'b1;
                    tr_wdata = cl_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (len_re)
        begin
            len_rd <= len_mem[len_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re)
        begin
            link_rd <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tr_we)
        begin
            tr_mem[tr_waddr] <= tr_wdata;
        end
        if (tr_re)
        begin
            tr_rd <= tr_mem[tr_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= ROOT;
            last_reg      <= ROOT;
            slen_reg      <= '0;
            total_reg     <= '0;
            j_reg         <= '0;
            cpv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= (out_valid_reg && !out_ready) || (op == OP_FIN) || (op == OP_SKIP);
            case (op)
                OP_CLR:
                begin
                    j_reg     <= j_next;
                    count_reg <= ROOT;
                    last_reg  <= ROOT;
                    slen_reg  <= '0;
                    total_reg <= '0;
                end
                OP_ALLOC:
                begin
                    count_reg <= cnt_new;
                    j_reg     <= '0;
                end
                OP_CLR_CUR:
                begin
                    j_reg <= j_next;
                end
                OP_CMP:
                begin
                    if (!stat.len_match)
                    begin
                        count_reg <= cnt_new;
                        j_reg     <= '0;
                        cpv_reg   <= 1'b0;
                    end
                end
                OP_COPY:
                begin
                    j_reg   <= j_next;
                    cpv_reg <= 1'b1;
                end
                OP_FIN:
                begin
                    last_reg  <= cur_reg;
                    total_reg <= total_reg + TOTAL_W'(added);
                    slen_reg  <= slen_reg + LW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LATCH:
            begin
                c_reg     <= CW'(symbol);
                ok_reg    <= (32'(symbol) < ALPHABET);
                start_reg <= start_new;
            end
            OP_ALLOC:
            begin
                cur_reg <= cnt_new;
                p_reg   <= last_reg;
            end
            OP_LEN_CUR:
            begin
                lencur_reg <= len_rd + LW'(1);
            end
            OP_W1_EX:
            begin
                if (tr_rd == '0)
                begin
                    p_reg <= link_rd;
                    if (link_rd == '0)
                    begin
                        lenlink_reg <= '0;
                    end
                end
                else
                begin
                    q_reg <= tr_rd;
                end
            end
            OP_RD_LQ:
            begin
                lenp_reg <= len_rd;
            end
            OP_CMP:
            begin
                if (stat.len_match)
                begin
                    lenlink_reg <= len_rd;
                end
                else
                begin
                    cl_reg      <= cnt_new;
                    lenlink_reg <= lenp_inc;
                end
            end
            OP_COPY:
            begin
                jd_reg <= j_reg;
            end
            OP_W2_EX:
            begin
                if (tr_rd == q_reg)
                begin
                    p_reg <= link_rd;
                end
            end
            OP_FIN:
            begin
                idx_reg  <= STATE_W'(cur_reg);
                new_reg  <= NEWSUB_W'(added);
                tot_reg  <= total_reg + TOTAL_W'(added);
                full_reg <= 1'b0;
            end
            OP_SKIP:
            begin
                idx_reg  <= STATE_W'(last_reg);
                new_reg  <= '0;
                tot_reg  <= total_reg;
                full_reg <= stat.full;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid        = out_valid_reg;
    assign state_index      = idx_reg;
    assign new_substrings   = new_reg;
    assign total_substrings = tot_reg;
    assign full_res         = full_reg;
endmodule

@@ rtl/sab_ctrl.sv @@
// ----------------------------------------------------------------------------
// Suffix automaton controller
// Sequences allocation, row clears, suffix-link walks and state clones.
// ----------------------------------------------------------------------------
module sab_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sab_pkg::stat_t stat,
    output sab_pkg::op_t   op
);
    import sab_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DECIDE, S_CLR, S_CHECK, S_SKIP, S_ALLOC, S_LEN_CUR,
        S_CLR_CUR, S_W1_RD, S_W1_EX, S_RD_LQ, S_CMP, S_CL_LINK, S_CL_LQ,
        S_CL_LC, S_COPY, S_COPY_TAIL, S_W2_RD, S_W2_EX, S_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                op = OP_CLR;
                if (stat.j_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LATCH;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.start)
                begin
                    state_next = S_CLR;
                end
                else if (stat.full || !stat.sym_ok)
                begin
                    state_next = S_SKIP;
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_CLR:
            begin
                op = OP_CLR;
                if (stat.j_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.sym_ok ? S_ALLOC : S_SKIP;
            end
            S_SKIP:
            begin
                if (!stat.out_busy)
                begin
                    op         = OP_SKIP;
                    state_next = S_IDLE;
                end
            end
            S_ALLOC:
            begin
                op         = OP_ALLOC;
                state_next = S_LEN_CUR;
            end
            S_LEN_CUR:
            begin
                op         = OP_LEN_CUR;
                state_next = S_CLR_CUR;
            end
            S_CLR_CUR:
            begin
                op = OP_CLR_CUR;
                if (stat.j_last)
                begin
                    state_next = S_W1_RD;
                end
            end
            S_W1_RD:
            begin
                op         = OP_W1_RD;
                state_next = S_W1_EX;
            end
            S_W1_EX:
            begin
                op = OP_W1_EX;
                if (!stat.tr_zero)
                begin
                    state_next = S_RD_LQ;
                end
                else if (stat.link_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_W1_RD;
                end
            end
            S_RD_LQ:
            begin
                op         = OP_RD_LQ;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                op         = OP_CMP;
                state_next = stat.len_match ? S_FIN : S_CL_LINK;
            end
            S_CL_LINK:
            begin
                op         = OP_CL_LINK;
                state_next = S_CL_LQ;
            end
            S_CL_LQ:
            begin
                op         = OP_CL_LQ;
                state_next = S_CL_LC;
            end
            S_CL_LC:
            begin
                op         = OP_CL_LC;
                state_next = S_COPY;
            end
            S_COPY:
            begin
                op = OP_COPY;
                if (stat.j_last)
                begin
                    state_next = S_COPY_TAIL;
                end
            end
            S_COPY_TAIL:
            begin
                op         = OP_COPY_TAIL;
                state_next = S_W2_RD;
            end
            S_W2_RD:
            begin
                op         = OP_W2_RD;
                state_next = S_W2_EX;
            end
            S_W2_EX:
            begin
                op = OP_W2_EX;
                if (stat.tr_is_q && !stat.link_zero)
                begin
                    state_next = S_W2_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    op         = OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
